// ===== hdl/hpf_pkg.sv =====
// -----------------------------------------------------------------------------
// HTTP host packet filter package
// Shared types and constants for the byte parser, the verdict queue and the
// top level.
// -----------------------------------------------------------------------------
package hpf_pkg;

   localparam int MAX_TARGET  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PATTERN_LEN = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LENGTH = 3'd4;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] queue_id;
   } req_type;

   typedef struct packed {
      logic [31:0] verdict_id;
      logic        accept;
      logic        host_seen;
   } rsp_type;

   function automatic logic [7:0] host_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h48;
         3'd1: c = 8'h6F;
         3'd2: c = 8'h73;
         3'd3: c = 8'h74;
         3'd4: c = 8'h3A;
         3'd5: c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/hpf_parser.sv =====
// -----------------------------------------------------------------------------
// HTTP host packet filter byte parser
// Walks the IPv4 and TCP headers, searches the payload for the host header
// and compares the name against the target registers, one byte per cycle.
// -----------------------------------------------------------------------------
module hpf_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [hpf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hpf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             in_valid,
   input  hpf_pkg::req_type                 in_item,
   output logic                             out_push,
   output hpf_pkg::rsp_type                 out_item
);
   import hpf_pkg::*;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_SEARCH  = 2'd1;
   localparam logic [1:0] PH_COMPARE = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   localparam logic [5:0] MAX_LEN = 6'((MAX_TARGET > 63) ? 63 : MAX_TARGET);
   localparam logic [2:0] PAT_LEN = 3'(PATTERN_LEN);

   logic [255:0] target_ff, target_in;
   logic [5:0]   length_ff, length_in;

   logic [15:0] pos_ff, pos_in;
   logic [5:0]  ihl_ff, ihl_in;
   logic [6:0]  pstart_ff, pstart_in;
   logic        tcp_ff, tcp_in;
   logic [2:0]  prog_ff, prog_in;
   logic [5:0]  cidx_ff, cidx_in;
   logic [1:0]  phase_ff, phase_in;
   logic        match_ff, match_in;

   logic [7:0]  b;
   logic [5:0]  doff;
   logic [5:0]  eff_len;
   logic [7:0]  tbyte;
   logic        seen;
   logic        drop;

   always_comb begin
      target_in = target_ff;
      length_in = length_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TARGET_WORD_0: target_in[63:0]    = csr_data;
            CSR_TARGET_WORD_1: target_in[127:64]  = csr_data;
            CSR_TARGET_WORD_2: target_in[191:128] = csr_data;
            CSR_TARGET_WORD_3: target_in[255:192] = csr_data;
            CSR_TARGET_LENGTH: length_in          = csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_len = (length_ff == 6'd0) ? 6'd1 : length_ff;
      if (eff_len > MAX_LEN) begin
         eff_len = MAX_LEN;
      end
   end

   assign b     = in_item.data_byte;
   assign doff  = {b[7:4], 2'b00};
   assign tbyte = cidx_ff[5] ? 8'h00 : target_ff[{cidx_ff[4:0], 3'b000} +: 8];

   always_comb begin
      pos_in    = pos_ff;
      ihl_in    = ihl_ff;
      pstart_in = pstart_ff;
      tcp_in    = tcp_ff;
      prog_in   = prog_ff;
      cidx_in   = cidx_ff;
      phase_in  = phase_ff;
      match_in  = match_ff;
      seen      = 1'b0;
      drop      = 1'b0;
      if (in_valid) begin
         case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == 16'd0) begin
                  ihl_in = {b[3:0], 2'b00};
               end
               if (pos_ff == 16'd9) begin
                  tcp_in = (b == 8'd6);
               end
               if (pos_ff == 16'(ihl_ff) + 16'd12) begin
                  pstart_in = 7'(ihl_ff) + 7'(doff);
                  phase_in  = (tcp_ff && doff != 6'd0) ? PH_SEARCH : PH_DONE;
               end
            end
            PH_SEARCH: begin
               if (pos_ff >= 16'(pstart_ff)) begin
                  if (b == 8'd0) begin
                     phase_in = PH_DONE;
                  end else if (b == host_char(prog_ff)) begin
                     prog_in = prog_ff + 3'd1;
                     if (prog_in >= PAT_LEN) begin
                        phase_in = PH_COMPARE;
                        cidx_in  = 6'd0;
                        match_in = 1'b1;
                     end
                  end else begin
                     prog_in = (b == host_char(3'd0)) ? 3'd1 : 3'd0;
                  end
               end
            end
            PH_COMPARE: begin
               if (b != tbyte) begin
                  match_in = 1'b0;
               end
               cidx_in = cidx_ff + 6'd1;
               if (cidx_in >= eff_len) begin
                  phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
         if (pos_ff != 16'hFFFF) begin
            pos_in = pos_ff + 16'd1;
         end
         seen = (phase_in == PH_COMPARE) || (prog_in >= PAT_LEN);
         drop = (phase_in == PH_DONE) && match_in;
         if (in_item.last_byte) begin
            pos_in    = 16'd0;
            ihl_in    = 6'd0;
            pstart_in = 7'd0;
            tcp_in    = 1'b0;
            prog_in   = 3'd0;
            cidx_in   = 6'd0;
            phase_in  = PH_HEADER;
            match_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         length_ff <= 6'd1;
         pos_ff    <= '0;
         ihl_ff    <= '0;
         pstart_ff <= '0;
         tcp_ff    <= 1'b0;
         prog_ff   <= '0;
         cidx_ff   <= '0;
         phase_ff  <= PH_HEADER;
         match_ff  <= 1'b0;
      end else begin
         target_ff <= target_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
         ihl_ff    <= ihl_in;
         pstart_ff <= pstart_in;
         tcp_ff    <= tcp_in;
         prog_ff   <= prog_in;
         cidx_ff   <= cidx_in;
         phase_ff  <= phase_in;
         match_ff  <= match_in;
      end
   end

   assign out_push            = in_valid && in_item.last_byte;
   assign out_item.verdict_id = in_item.queue_id;
   assign out_item.accept     = !drop;
   assign out_item.host_seen  = seen;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_item.last_byte |=> pos_ff == 16'd0 && phase_ff == PH_HEADER)
      else $error("parser state not cleared after last byte");

   a_compare_after_pattern: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COMPARE |-> prog_ff == PAT_LEN && cidx_ff < eff_len)
      else $error("compare phase without full pattern or index past length");

   a_drop_needs_seen: assert property (@(posedge clock) disable iff (reset)
      out_push && !out_item.accept |-> out_item.host_seen)
      else $error("drop verdict without host header");

endmodule

// ===== hdl/hpf_queue.sv =====
// -----------------------------------------------------------------------------
// HTTP host packet filter verdict queue
// Short queue between the byte parser and the result channel; holds verdicts
// until the consumer pops them.
// -----------------------------------------------------------------------------
module hpf_queue #(
   parameter int DEPTH = hpf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hpf_pkg::rsp_type push_item,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output hpf_pkg::rsp_type head_item
);
   import hpf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rsp_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("verdict pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable(head_item) && !empty)
      else $error("queue head changed without pop");

endmodule

// ===== hdl/http_host_packet_filter.sv =====
// A verdict is ready to pop (rsp_empty low) in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while req_full is low; the parser state advances once per accepted byte.
// req_full rises only while QUEUE_DEPTH verdicts wait unpopped in the verdict queue.
// Reset: target words clear to zero, target length to one, parser returns to the
// header phase and the queue empties; no clearing pass.
// -----------------------------------------------------------------------------
// HTTP host packet filter
// Parses IPv4/TCP packets byte by byte and drops those whose host header
// names the configured target.
// -----------------------------------------------------------------------------
module http_host_packet_filter #(
   parameter int QUEUE_DEPTH = hpf_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hpf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hpf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_push,
   output logic                             req_full,
   input  hpf_pkg::req_type                 req_payload,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output hpf_pkg::rsp_type                 rsp_payload
);
   import hpf_pkg::*;

   logic    req_accept;
   logic    verdict_push;
   rsp_type verdict_item;

   assign csr_ready  = 1'b1;
   assign req_accept = req_push && !req_full;

   hpf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_valid  (req_accept),
      .in_item   (req_payload),
      .out_push  (verdict_push),
      .out_item  (verdict_item)
   );

   hpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (verdict_push),
      .push_item (verdict_item),
      .full      (req_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_item (rsp_payload)
   );

   a_verdict_only_on_last: assert property (@(posedge clock) disable iff (reset)
      verdict_push |-> req_accept && req_payload.last_byte)
      else $error("verdict without last byte");

   a_verdict_lands: assert property (@(posedge clock) disable iff (reset)
      verdict_push |=> !rsp_empty)
      else $error("verdict not visible after push");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !verdict_push)
      else $error("verdict produced while queue full");

endmodule
